// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants
// Operation and status codes, task stage codes, sequencer states and the
// control bundle between the sequencer and the task table.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int unsigned TASK_COUNT_DEF  = 8;
	localparam int unsigned STACK_WORDS_DEF = 256;
	localparam int unsigned FRAME_BYTES     = 128;
	localparam int unsigned PADDR_W         = 2;

	localparam logic [PADDR_W-1:0] ADDR_STACK_BASE = PADDR_W'(0);

	localparam logic [1:0] FUNC_CREATE   = 2'd0;
	localparam logic [1:0] FUNC_SCHEDULE = 2'd1;
	localparam logic [1:0] FUNC_START    = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_RANGE    = 2'd1;
	localparam logic [1:0] STATUS_NO_READY = 2'd2;

	typedef enum logic [1:0] {
		TS_IDLE  = 2'd0,
		TS_READY = 2'd1,
		TS_RUN   = 2'd2
	} stage_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CREATE,
		S_SCAN,
		S_PICK,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic   stage_we;
		stage_t stage_wval;
		logic   sp_we;
		logic   sp_re;
	} tbl_ctl_t;

endpackage

// ===== rtl/rrts_if.sv =====
// ----------------------------------------------------------------------------
// rrts_if: request and response channels
// Valid/ready channels carrying one operation beat and one result beat.
// ----------------------------------------------------------------------------
interface rrts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [3:0]  task_number;
	logic        has_entry;
	logic [31:0] outgoing_sp;

	modport source (output valid, func, task_number, has_entry, outgoing_sp, input ready);
	modport sink   (input valid, func, task_number, has_entry, outgoing_sp, output ready);
endinterface

interface rrts_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  chosen_task;
	logic [31:0] chosen_sp;

	modport source (output valid, status, chosen_task, chosen_sp, input ready);
	modport sink   (input valid, status, chosen_task, chosen_sp, output ready);
endinterface

// ===== rtl/rrts_cfg.sv =====
// ----------------------------------------------------------------------------
// rrts_cfg: configuration register port
// APB-style slave holding the stack region base address.
// ----------------------------------------------------------------------------
module rrts_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrts_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [31:0]                  stack_base
);

	logic [31:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && paddr == rrts_pkg::ADDR_STACK_BASE) begin
			base_q <= pwdata;
		end
	end

	assign prdata     = (paddr == rrts_pkg::ADDR_STACK_BASE) ? base_q : '0;
	assign pready     = 1'b1;
	assign stack_base = base_q;

endmodule

// ===== rtl/rrts_table.sv =====
// ----------------------------------------------------------------------------
// rrts_table: task table
// Per-task stage registers and the saved stack pointer memory, one access
// index per cycle, registered pointer read with entry valid bits.
// ----------------------------------------------------------------------------
module rrts_table #(
	parameter int unsigned TASK_COUNT = rrts_pkg::TASK_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(TASK_COUNT)-1:0] idx,
	input  rrts_pkg::tbl_ctl_t            ctl,
	input  logic [31:0]                   sp_wdata,
	output rrts_pkg::stage_t              stage_rd,
	output logic [31:0]                   sp_rd
);

	rrts_pkg::stage_t        stage_q [TASK_COUNT];
	logic [TASK_COUNT-1:0]   vld_q;
	logic [31:0]             sp_mem [TASK_COUNT];
	logic [31:0]             sp_rdata_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				stage_q[i] <= rrts_pkg::TS_IDLE;
			end
			vld_q <= '0;
		end else begin
			if (ctl.stage_we) begin
				stage_q[idx] <= ctl.stage_wval;
			end
			if (ctl.sp_we) begin
				vld_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sp_we) begin
			sp_mem[idx] <= sp_wdata;
		end
		if (ctl.sp_re) begin
			sp_rdata_q <= sp_mem[idx];
			rd_vld_q   <= vld_q[idx];
		end
	end

	assign stage_rd = stage_q[idx];
	assign sp_rd    = rd_vld_q ? sp_rdata_q : '0;

endmodule

// ===== rtl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl: operation sequencer
// Decodes one request beat, walks the task table one slot per cycle with a
// shared modulo incrementer, computes create pointers and holds the result.
// ----------------------------------------------------------------------------
module rrts_ctrl #(
	parameter int unsigned TASK_COUNT  = rrts_pkg::TASK_COUNT_DEF,
	parameter int unsigned STACK_WORDS = rrts_pkg::STACK_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [31:0]                   stack_base,
	rrts_req_if.sink                      req,
	rrts_rsp_if.source                    rsp,
	output logic [$clog2(TASK_COUNT)-1:0] idx,
	output rrts_pkg::tbl_ctl_t            ctl,
	output logic [31:0]                   sp_wdata,
	input  rrts_pkg::stage_t              stage_rd,
	input  logic [31:0]                   sp_rd
);

	localparam int unsigned IW         = $clog2(TASK_COUNT);
	localparam int unsigned SLOT_BYTES = STACK_WORDS * 4;
	localparam logic [31:0] SLOT_TOP   = 32'(SLOT_BYTES - rrts_pkg::FRAME_BYTES);
	localparam logic [IW-1:0] LAST_IDX = IW'(TASK_COUNT - 1);
	localparam logic [IW-1:0] RUN_RST  = IW'(1 % TASK_COUNT);

	rrts_pkg::state_t state_q, state_d;

	logic [1:0]    func_q;
	logic [3:0]    tid_q;
	logic          has_entry_q;
	logic [31:0]   osp_q;
	logic [IW-1:0] running_q;
	logic [IW-1:0] scan_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] pick_q;
	logic [31:0]   off_q;
	logic [1:0]    res_status_q;
	logic [2:0]    res_task_q;
	logic [31:0]   res_sp_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [2:0]    out_task_q;
	logic [31:0]   out_sp_q;

	logic [6:0]    tid_ext;
	logic [IW-1:0] tid_idx;
	logic          tid_bad;
	logic [IW-1:0] step_in;
	logic [IW-1:0] step_out;
	logic          found;
	logic          scan_last;
	logic          out_free;
	logic [31:0]   create_sp;

	assign tid_ext   = 7'(tid_q);
	assign tid_idx   = tid_ext[IW-1:0];
	assign tid_bad   = tid_ext >= 7'(TASK_COUNT);
	assign step_in   = (state_q == rrts_pkg::S_DECODE) ? running_q : scan_q;
	assign step_out  = (step_in == LAST_IDX) ? '0 : step_in + 1'b1;
	assign found     = stage_rd == rrts_pkg::TS_READY;
	assign scan_last = cnt_q == LAST_IDX;
	assign out_free  = !out_valid_q || rsp.ready;
	assign create_sp = has_entry_q ? stack_base + off_q + SLOT_TOP : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrts_pkg::S_IDLE: begin
				if (req.valid) state_d = rrts_pkg::S_DECODE;
			end
			rrts_pkg::S_DECODE: begin
				case (func_q)
					rrts_pkg::FUNC_CREATE:   state_d = tid_bad ? rrts_pkg::S_DONE : rrts_pkg::S_CREATE;
					rrts_pkg::FUNC_SCHEDULE: state_d = rrts_pkg::S_SCAN;
					rrts_pkg::FUNC_START:    state_d = rrts_pkg::S_SCAN;
					default:                 state_d = rrts_pkg::S_READ;
				endcase
			end
			rrts_pkg::S_CREATE: state_d = rrts_pkg::S_DONE;
			rrts_pkg::S_SCAN: begin
				if (found) begin
					state_d = rrts_pkg::S_PICK;
				end else if (scan_last) begin
					state_d = (func_q == rrts_pkg::FUNC_START) ? rrts_pkg::S_DONE : rrts_pkg::S_PICK;
				end
			end
			rrts_pkg::S_PICK: state_d = rrts_pkg::S_READ;
			rrts_pkg::S_READ: state_d = rrts_pkg::S_DONE;
			rrts_pkg::S_DONE: begin
				if (out_free) state_d = rrts_pkg::S_IDLE;
			end
			default: state_d = rrts_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		idx            = pick_q;
		ctl            = '0;
		ctl.stage_wval = rrts_pkg::TS_READY;
		sp_wdata       = osp_q;
		case (state_q)
			rrts_pkg::S_DECODE: begin
				case (func_q)
					rrts_pkg::FUNC_CREATE: idx = tid_idx;
					rrts_pkg::FUNC_SCHEDULE: begin
						idx          = running_q;
						ctl.stage_we = stage_rd == rrts_pkg::TS_RUN;
						ctl.sp_we    = 1'b1;
					end
					rrts_pkg::FUNC_START: idx = running_q;
					default: begin
						idx        = running_q;
						ctl.sp_re  = 1'b1;
					end
				endcase
			end
			rrts_pkg::S_CREATE: begin
				idx          = tid_idx;
				ctl.stage_we = 1'b1;
				ctl.sp_we    = 1'b1;
				sp_wdata     = create_sp;
			end
			rrts_pkg::S_SCAN: idx = scan_q;
			rrts_pkg::S_PICK: begin
				ctl.stage_we   = 1'b1;
				ctl.stage_wval = rrts_pkg::TS_RUN;
				ctl.sp_re      = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrts_pkg::S_IDLE;
			running_q   <= RUN_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rrts_pkg::S_PICK) begin
				running_q <= pick_q;
			end
			if (state_q == rrts_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rrts_pkg::S_IDLE: begin
				func_q      <= req.func;
				tid_q       <= req.task_number;
				has_entry_q <= req.has_entry;
				osp_q       <= req.outgoing_sp;
			end
			rrts_pkg::S_DECODE: begin
				off_q        <= 32'(tid_idx) * 32'(SLOT_BYTES);
				scan_q       <= (func_q == rrts_pkg::FUNC_SCHEDULE) ? step_out : '0;
				cnt_q        <= '0;
				pick_q       <= running_q;
				res_status_q <= rrts_pkg::STATUS_RANGE;
				res_task_q   <= '0;
				res_sp_q     <= '0;
			end
			rrts_pkg::S_CREATE: begin
				res_status_q <= rrts_pkg::STATUS_OK;
				res_task_q   <= 3'(tid_idx);
				res_sp_q     <= create_sp;
			end
			rrts_pkg::S_SCAN: begin
				if (found) begin
					pick_q <= scan_q;
				end else if (scan_last) begin
					pick_q       <= running_q;
					res_status_q <= rrts_pkg::STATUS_NO_READY;
				end else begin
					scan_q <= step_out;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
			rrts_pkg::S_READ: begin
				res_status_q <= rrts_pkg::STATUS_OK;
				res_task_q   <= 3'(pick_q);
				res_sp_q     <= sp_rd;
			end
			rrts_pkg::S_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_task_q   <= res_task_q;
					out_sp_q     <= res_sp_q;
				end
			end
			default: ;
		endcase
	end

	assign req.ready       = state_q == rrts_pkg::S_IDLE;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.chosen_task = out_task_q;
	assign rsp.chosen_sp   = out_sp_q;

endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: hardware task table with round-robin switching
// Requests arrive as beats on req (create, schedule, start); each returns one
// result beat on rsp with a status, the chosen task and its stack pointer.
// The stack region base is set through the APB port at byte address 0.
//
// One request is in flight at a time; req.ready is high only when idle.
// Create decodes the request and multiplies out the slot offset, then adds
// the base and slot top. Schedule and start walk the task stages one slot per
// cycle through a shared modulo incrementer, stopping early when a ready
// task turns up. The unused function code returns the running task's pointer.
// The result sits in an output register; a new request may be accepted
// while it waits, and a finished one holds until rsp drains.
// Reset marks every task idle, clears every saved pointer's valid bit so it reads as zero,
// sets the running task to one and the stack base to zero; the block is ready right after.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
	parameter int unsigned TASK_COUNT  = rrts_pkg::TASK_COUNT_DEF,
	parameter int unsigned STACK_WORDS = rrts_pkg::STACK_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rrts_req_if.sink                     req,
	rrts_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrts_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int unsigned IW = $clog2(TASK_COUNT);

	logic [31:0]        stack_base;
	logic [IW-1:0]      idx;
	rrts_pkg::tbl_ctl_t ctl;
	logic [31:0]        sp_wdata;
	rrts_pkg::stage_t   stage_rd;
	logic [31:0]        sp_rd;

	rrts_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.stack_base (stack_base)
	);

	rrts_table #(
		.TASK_COUNT (TASK_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.idx      (idx),
		.ctl      (ctl),
		.sp_wdata (sp_wdata),
		.stage_rd (stage_rd),
		.sp_rd    (sp_rd)
	);

	rrts_ctrl #(
		.TASK_COUNT  (TASK_COUNT),
		.STACK_WORDS (STACK_WORDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.stack_base (stack_base),
		.req        (req),
		.rsp        (rsp),
		.idx        (idx),
		.ctl        (ctl),
		.sp_wdata   (sp_wdata),
		.stage_rd   (stage_rd),
		.sp_rd      (sp_rd)
	);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: round_robin_task_scheduler
// Drives create, schedule and start requests with random gaps and result
// stalls. A task-table predictor inside the bench tracks stages, saved stack
// pointers and the running task, and each result beat is checked field by
// field against it. The stack base register is rewritten between phases,
// including both extremes, and read back.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned NTASK      = rrts_pkg::TASK_COUNT_DEF;
	localparam int unsigned SLOT_BYTES = rrts_pkg::STACK_WORDS_DEF * 4;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  chosen_task;
		logic [31:0] chosen_sp;
	} dispatch_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [rrts_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	rrts_req_if req_ch();
	rrts_rsp_if rsp_ch();

	round_robin_task_scheduler #(
		.TASK_COUNT  (NTASK),
		.STACK_WORDS (rrts_pkg::STACK_WORDS_DEF)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rrts_pkg::stage_t tcb_stage [NTASK];
	logic [31:0]      tcb_sp    [NTASK];
	logic [2:0]       cur_task;
	logic [31:0]      slot_base;

	dispatch_t dispatch_due [$];
	int        err_count    = 0;
	bit        calm         = 1'b0;
	bit        hold_request = 1'b0;
	int        stall_left   = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic dispatch_t next_dispatch(input logic [1:0] op, input logic [3:0] tn,
			input logic he, input logic [31:0] osp);
		dispatch_t   r;
		int unsigned idx;
		int unsigned cur;
		int unsigned nxt;
		int unsigned k;
		bit          found;
		r     = '0;
		idx   = tn;
		cur   = cur_task;
		nxt   = cur;
		found = 1'b0;
		case (op)
			rrts_pkg::FUNC_CREATE: begin
				if (idx >= NTASK) begin
					r.status = rrts_pkg::STATUS_RANGE;
				end else begin
					tcb_sp[idx] = he ? slot_base + 32'((idx + 1) * SLOT_BYTES)
						- 32'(rrts_pkg::FRAME_BYTES) : 32'h0;
					tcb_stage[idx] = rrts_pkg::TS_READY;
					r.chosen_task  = 3'(idx);
					r.chosen_sp    = tcb_sp[idx];
				end
			end
			rrts_pkg::FUNC_SCHEDULE: begin
				if (tcb_stage[cur] == rrts_pkg::TS_RUN)
					tcb_stage[cur] = rrts_pkg::TS_READY;
				tcb_sp[cur] = osp;
				for (k = 1; k <= NTASK && !found; k++) begin
					if (tcb_stage[(cur + k) % NTASK] == rrts_pkg::TS_READY) begin
						nxt   = (cur + k) % NTASK;
						found = 1'b1;
					end
				end
				cur_task       = 3'(nxt);
				tcb_stage[nxt] = rrts_pkg::TS_RUN;
				r.chosen_task  = 3'(nxt);
				r.chosen_sp    = tcb_sp[nxt];
			end
			rrts_pkg::FUNC_START: begin
				for (k = 0; k < NTASK && !found; k++) begin
					if (tcb_stage[k] == rrts_pkg::TS_READY) begin
						nxt   = k;
						found = 1'b1;
					end
				end
				if (!found) begin
					r.status = rrts_pkg::STATUS_NO_READY;
				end else begin
					cur_task       = 3'(nxt);
					tcb_stage[nxt] = rrts_pkg::TS_RUN;
					r.chosen_task  = 3'(nxt);
					r.chosen_sp    = tcb_sp[nxt];
				end
			end
			default: begin
				r.chosen_task = 3'(cur);
				r.chosen_sp   = tcb_sp[cur];
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		dispatch_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (dispatch_due.size() == 0) begin
				$error("unexpected result beat: status %0d, task %0d, sp %h",
					rsp_ch.status, rsp_ch.chosen_task, rsp_ch.chosen_sp);
				err_count++;
			end else begin
				exp_r = dispatch_due.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.chosen_task !== exp_r.chosen_task) begin
					$error("chosen_task: expected %0d, got %0d",
						exp_r.chosen_task, rsp_ch.chosen_task);
					err_count++;
				end
				if (rsp_ch.chosen_sp !== exp_r.chosen_sp) begin
					$error("chosen_sp: expected %h, got %h", exp_r.chosen_sp, rsp_ch.chosen_sp);
					err_count++;
				end
			end
		end
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = 59;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic issue_op(input logic [1:0] op, input logic [3:0] tn, input logic he,
			input logic [31:0] osp);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= op;
		req_ch.task_number <= tn;
		req_ch.has_entry   <= he;
		req_ch.outgoing_sp <= osp;
		do @(posedge clk); while (!req_ch.ready);
		dispatch_due.push_back(next_dispatch(op, tn, he, osp));
	endtask

	task automatic issue_random();
		int unsigned pick;
		logic [3:0]  tn;
		pick = $urandom_range(0, 99);
		tn   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
		if (pick < 30)
			issue_op(rrts_pkg::FUNC_CREATE, tn, 1'($urandom), $urandom);
		else if (pick < 80)
			issue_op(rrts_pkg::FUNC_SCHEDULE, 4'($urandom), 1'($urandom), $urandom);
		else
			issue_op(rrts_pkg::FUNC_START, 4'($urandom), 1'($urandom), $urandom);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (dispatch_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_base(input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= rrts_pkg::ADDR_STACK_BASE;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		slot_base = value;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("stack_region_base: expected %h, got %h", value, prdata);
			err_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed();
		issue_op(rrts_pkg::FUNC_START,    4'd0,  1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b0, 32'hFFFF_FFFF);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b0, 32'h8000_0000);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd15, 1'b1, 32'h0);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd8,  1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd0,  1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd7,  1'b1, 32'h0);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd1,  1'b1, 32'h0);
		issue_op(rrts_pkg::FUNC_START,    4'd0,  1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b1, 32'h1234_5678);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd15, 1'b0, 32'hFFFF_FFFF);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd0,  1'b1, 32'h0);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b0, 32'hDEAD_BEEF);
		issue_op(rrts_pkg::FUNC_START,    4'd0,  1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd3,  1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b0, 32'h0000_0004);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b0, 32'h5555_5555);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0,  1'b0, 32'hAAAA_AAAA);
		issue_op(rrts_pkg::FUNC_START,    4'd9,  1'b1, 32'h0);
		drain();
	endtask

	task automatic test_slot_base_wrap();
		int unsigned t;
		write_base(32'hFFFF_FFFF);
		for (t = 0; t < NTASK; t++)
			issue_op(rrts_pkg::FUNC_CREATE, 4'(t), 1'b1, 32'h0);
		issue_op(rrts_pkg::FUNC_CREATE,   4'd2, 1'b0, 32'h0);
		issue_op(rrts_pkg::FUNC_SCHEDULE, 4'd0, 1'b0, $urandom);
		issue_op(rrts_pkg::FUNC_START,    4'd0, 1'b0, 32'h0);
		drain();
	endtask

	task automatic test_random_traffic(input logic [31:0] base, input int n);
		write_base(base);
		repeat (n) issue_random();
		drain();
	endtask

	task automatic test_output_backpressure();
		hold_request = 1'b1;
		repeat (25) issue_random();
		drain();
	endtask

	task automatic test_calm_tail();
		calm = 1'b1;
		write_base($urandom);
		repeat (60) issue_random();
		drain();
	endtask

	initial begin
		int unsigned i;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.func        <= rrts_pkg::FUNC_CREATE;
		req_ch.task_number <= '0;
		req_ch.has_entry   <= 1'b0;
		req_ch.outgoing_sp <= '0;
		for (i = 0; i < NTASK; i++) begin
			tcb_stage[i] = rrts_pkg::TS_IDLE;
			tcb_sp[i]    = '0;
		end
		cur_task  = 3'(1 % NTASK);
		slot_base = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_slot_base_wrap();
		test_random_traffic(32'h0000_0000, 100);
		test_random_traffic($urandom, 100);
		test_output_backpressure();
		test_random_traffic(32'hFFFF_FFFF, 70);
		test_calm_tail();

		repeat (30) @(posedge clk);
		if (err_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
